// ----- design/lvm_pkg.sv -----
package lvm_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int ADDR_W     = $clog2(MAX_FRAMES);
  localparam int POS_W      = $clog2(MAX_FRAMES + 1);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_RENDER = 2'd1,
    REQ_REWIND = 2'd2
  } req_t;

  localparam logic [1:0] CFG_VOL_LEFT      = 2'd0;
  localparam logic [1:0] CFG_VOL_RIGHT     = 2'd1;
  localparam logic [1:0] CFG_LOOP_ENABLE   = 2'd2;
  localparam logic [1:0] CFG_BUFFER_FRAMES = 2'd3;

  typedef struct packed {
    logic [15:0] vol_left;
    logic [15:0] vol_right;
    logic        loop_enable;
    logic [12:0] buffer_frames;
  } cfg_t;

  // one classified word handed from the front to the mixing back end
  typedef struct packed {
    logic               played;
    logic               finished;
    logic [POS_W-1:0]   position;
    logic signed [31:0] acc_left;
    logic signed [31:0] acc_right;
    logic signed [15:0] smp_left;
    logic signed [15:0] smp_right;
  } q_item_t;

endpackage

// ----- design/lvm_front.sv -----
module lvm_front (
  input  logic                clk,
  input  logic                rst,
  input  lvm_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          req_type,
  input  logic [11:0]         load_addr,
  input  logic signed [15:0]  load_left,
  input  logic signed [15:0]  load_right,
  input  logic signed [31:0]  acc_left,
  input  logic signed [31:0]  acc_right,
  output logic                q_push,
  output lvm_pkg::q_item_t    q_item,
  input  logic                q_full
);
  import lvm_pkg::*;

  logic [31:0]       sample_mem [MAX_FRAMES];
  logic [31:0]       rd_data;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  pos_next;
  logic [POS_W-1:0]  pos_w;
  logic [POS_W-1:0]  len;
  logic              accept;
  logic              play;
  logic              s1_valid;
  logic              s1_played;
  logic              s1_finished;
  logic [POS_W-1:0]  s1_position;
  logic signed [31:0] s1_acc_left;
  logic signed [31:0] s1_acc_right;
  req_t              req;

  assign req      = req_t'(req_type);
  assign in_ready = !s1_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = s1_valid && !q_full;

  // length clamped to the memory size
  assign len = (cfg.buffer_frames > POS_W'(MAX_FRAMES)) ? POS_W'(MAX_FRAMES)
                                                        : cfg.buffer_frames;

  always_comb begin
    pos_w = pos;
    if (pos >= len && cfg.loop_enable && len != '0) begin
      pos_w = '0;
    end
    play     = 1'b0;
    pos_next = pos;
    unique case (req)
      REQ_LOAD: begin
        pos_next = pos;
      end
      REQ_RENDER: begin
        play     = (pos_w < len);
        pos_next = play ? pos_w + POS_W'(1) : pos_w;
      end
      REQ_REWIND: begin
        pos_next = '0;
      end
      default: begin
        pos_next = pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && req == REQ_LOAD && {1'b0, load_addr} < 13'(MAX_FRAMES)) begin
      sample_mem[load_addr[ADDR_W-1:0]] <= {load_right, load_left};
    end
    if (accept) begin
      rd_data <= sample_mem[pos_w[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= pos_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (q_push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_played    <= play;
      s1_finished  <= !cfg.loop_enable && (pos_next >= len);
      s1_position  <= pos_next;
      s1_acc_left  <= acc_left;
      s1_acc_right <= acc_right;
    end
  end

  always_comb begin
    q_item.played    = s1_played;
    q_item.finished  = s1_finished;
    q_item.position  = s1_position;
    q_item.acc_left  = s1_acc_left;
    q_item.acc_right = s1_acc_right;
    q_item.smp_left  = rd_data[15:0];
    q_item.smp_right = rd_data[31:16];
  end

endmodule

// ----- design/lvm_queue.sv -----
module lvm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lvm_pkg::q_item_t din,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output lvm_pkg::q_item_t dout
);
  import lvm_pkg::*;

  q_item_t              slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign dout      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule

// ----- design/lvm_back.sv -----
module lvm_back (
  input  logic                clk,
  input  logic                rst,
  input  lvm_pkg::cfg_t       cfg,
  input  logic                q_valid,
  input  lvm_pkg::q_item_t    q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  mix_left,
  output logic signed [31:0]  mix_right,
  output logic                frame_played,
  output logic [12:0]         position,
  output logic                finished
);
  import lvm_pkg::*;

  logic               m_valid;
  logic               m_take;
  logic               o_load;
  logic signed [32:0] prod_left_full;
  logic signed [32:0] prod_right_full;
  logic [31:0]        m_prod_left;
  logic [31:0]        m_prod_right;
  logic [31:0]        m_acc_left;
  logic [31:0]        m_acc_right;
  logic               m_played;
  logic               m_finished;
  logic [POS_W-1:0]   m_position;

  assign o_load = !out_valid || out_ready;
  assign m_take = !m_valid || o_load;
  assign q_pop  = q_valid && m_take;

  // signed sample times unsigned gain, low 32 bits kept
  assign prod_left_full  = q_item.smp_left * $signed({1'b0, cfg.vol_left});
  assign prod_right_full = q_item.smp_right * $signed({1'b0, cfg.vol_right});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (m_take) begin
        m_valid <= q_valid;
      end
      if (o_load) begin
        out_valid <= m_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_prod_left  <= prod_left_full[31:0];
      m_prod_right <= prod_right_full[31:0];
      m_acc_left   <= q_item.acc_left;
      m_acc_right  <= q_item.acc_right;
      m_played     <= q_item.played;
      m_finished   <= q_item.finished;
      m_position   <= q_item.position;
    end
    if (o_load && m_valid) begin
      mix_left     <= m_acc_left + (m_played ? m_prod_left : 32'd0);
      mix_right    <= m_acc_right + (m_played ? m_prod_right : 32'd0);
      frame_played <= m_played;
      position     <= m_position;
      finished     <= m_finished;
    end
  end

endmodule

// ----- design/looping_sample_voice_mixer.sv -----
// path: an input word passes the front register, queue, product register and
// output register; throughput: one word per cycle while m_tready is high, with
// a single write and single read port on the front stage sample memory
// reset: clears the play position, the queue and pipeline, and sets the gains to
// 0x100, looping off and length zero; the sample memory is not cleared
module looping_sample_voice_mixer (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // load_addr, load_left, load_right, acc_left, acc_right, zero pad
  input  logic [111:0]  s_tdata,
  // req_type
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // mix_left, mix_right, position, finished, zero pad
  output logic [79:0]   m_tdata,
  // frame_played
  output logic          m_tuser,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import lvm_pkg::*;

  cfg_t               cfg;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_valid;
  q_item_t            q_in;
  q_item_t            q_out;
  logic signed [31:0] mix_left;
  logic signed [31:0] mix_right;
  logic               frame_played;
  logic [12:0]        position;
  logic               finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.vol_left      <= 16'h0100;
      cfg.vol_right     <= 16'h0100;
      cfg.loop_enable   <= 1'b0;
      cfg.buffer_frames <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOL_LEFT:      cfg.vol_left      <= cfg_data;
        CFG_VOL_RIGHT:     cfg.vol_right     <= cfg_data;
        CFG_LOOP_ENABLE:   cfg.loop_enable   <= cfg_data[0];
        CFG_BUFFER_FRAMES: cfg.buffer_frames <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  lvm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .req_type   (s_tuser),
    .load_addr  (s_tdata[11:0]),
    .load_left  (s_tdata[27:12]),
    .load_right (s_tdata[43:28]),
    .acc_left   (s_tdata[75:44]),
    .acc_right  (s_tdata[107:76]),
    .q_push     (q_push),
    .q_item     (q_in),
    .q_full     (q_full)
  );

  lvm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .din       (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_out)
  );

  lvm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .mix_left     (mix_left),
    .mix_right    (mix_right),
    .frame_played (frame_played),
    .position     (position),
    .finished     (finished)
  );

  assign m_tdata = {2'b00, finished, position, mix_right, mix_left};
  assign m_tuser = frame_played;

endmodule

// ----- design/lvm_checker.sv -----
module lvm_checker (
  input logic          clk,
  input logic          rst,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [79:0]   m_tdata,
  input logic          m_tuser
);
  import lvm_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // a mixed frame always leaves the position past zero
  a_played_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[76:64] != 13'd0)
    else $error("frame mixed but position reads zero");

  // position never runs past the memory size
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[76:64] <= 13'(MAX_FRAMES))
    else $error("position beyond memory size");

endmodule

bind looping_sample_voice_mixer lvm_checker u_lvm_checker (.*);

// ----- test/tb.sv -----
module tb;
  import lvm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_FRAMES = 64;

  typedef struct packed {
    logic [31:0]      mix_left;
    logic [31:0]      mix_right;
    logic             played;
    logic [POS_W-1:0] position;
    logic             finished;
  } mix_word_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic [1:0]  req;
    logic [11:0] addr;
    logic [15:0] smp_l;
    logic [15:0] smp_r;
    logic [31:0] acc_l;
    logic [31:0] acc_r;
    bit          typed;
    mix_word_t   want;
  } plan_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [79:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  int tx_idle_pct = 32;
  int rx_idle_pct = 61;
  int error_count = 0;
  int stall_cycles = 0;

  // voice state as the block should hold it
  logic [31:0]      sample_mem [MAX_FRAMES];
  bit               frame_written [MAX_FRAMES];
  logic [POS_W-1:0] play_pos = '0;
  logic [15:0]      gain_left = 16'h0100;
  logic [15:0]      gain_right = 16'h0100;
  logic             loop_on = 1'b0;
  logic [12:0]      frame_count = '0;

  mix_word_t due_words [$];
  mix_word_t due_word;
  plan_row_t plan [$];

  looping_sample_voice_mixer i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  function automatic logic [POS_W-1:0] active_len();
    return (frame_count > MAX_FRAMES) ? POS_W'(MAX_FRAMES) : frame_count;
  endfunction

  function automatic logic [31:0] scaled_sample(input logic [15:0] smp, input logic [15:0] gain);
    int prod;
    // fits in 32 bits signed: |-32768 * 65535| < 2^31
    prod = int'($signed(smp)) * int'(gain);
    return 32'(prod);
  endfunction

  function automatic mix_word_t voice_step(input logic [1:0] req, input logic [11:0] addr,
                                           input logic [15:0] sl, input logic [15:0] sr,
                                           input logic [31:0] al, input logic [31:0] ar);
    mix_word_t w;
    logic [POS_W-1:0] len;
    logic [31:0] fr;
    len = active_len();
    w.mix_left = al;
    w.mix_right = ar;
    w.played = 1'b0;
    if (req == REQ_LOAD) begin
      sample_mem[addr] = {sr, sl};
      frame_written[addr] = 1'b1;
    end else if (req == REQ_RENDER) begin
      if (play_pos >= len && loop_on && len != 0) begin
        play_pos = '0;
      end
      if (play_pos < len) begin
        fr = sample_mem[play_pos[ADDR_W-1:0]];
        w.mix_left = al + scaled_sample(fr[15:0], gain_left);
        w.mix_right = ar + scaled_sample(fr[31:16], gain_right);
        play_pos = play_pos + 1'b1;
        w.played = 1'b1;
      end
    end else if (req == REQ_REWIND) begin
      play_pos = '0;
    end
    w.position = play_pos;
    w.finished = !loop_on && play_pos >= len;
    return w;
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'h0100;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_acc();
    case ($urandom_range(11))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] req, input logic [11:0] addr,
                           input logic [15:0] sl, input logic [15:0] sr,
                           input logic [31:0] al, input logic [31:0] ar);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {4'b0, ar, al, sr, sl, addr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic play_word(input logic [1:0] req, input logic [11:0] addr,
                           input logic [15:0] sl, input logic [15:0] sr,
                           input logic [31:0] al, input logic [31:0] ar);
    send_word(req, addr, sl, sr, al, ar);
    due_words.push_back(voice_step(req, addr, sl, sr, al, ar));
  endtask

  // block must be idle before any register write
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_VOL_LEFT:      gain_left = val;
      CFG_VOL_RIGHT:     gain_right = val;
      CFG_LOOP_ENABLE:   loop_on = val[0];
      CFG_BUFFER_FRAMES: frame_count = val[12:0];
      default: ;
    endcase
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    plan.push_back(r);
  endtask

  task automatic add_row(input int typed, input logic [1:0] req, input logic [11:0] addr,
                         input logic [15:0] sl, input logic [15:0] sr,
                         input logic [31:0] al, input logic [31:0] ar,
                         input logic [31:0] ml, input logic [31:0] mr, input int pl,
                         input int pos, input int fin);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.req = req;
    r.addr = addr;
    r.smp_l = sl;
    r.smp_r = sr;
    r.acc_l = al;
    r.acc_r = ar;
    r.typed = (typed != 0);
    r.want = '{mix_left: ml, mix_right: mr, played: 1'(pl), position: POS_W'(pos),
               finished: 1'(fin)};
    plan.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_words.size() == 0) begin
        $display("%0t result word with none expected: expected none actual %h/%b",
                 $time, m_tdata, m_tuser);
        error_count++;
      end else begin
        due_word = due_words.pop_front();
        check_field("mix_left", due_word.mix_left, m_tdata[31:0]);
        check_field("mix_right", due_word.mix_right, m_tdata[63:32]);
        check_field("position", 32'(due_word.position), 32'(m_tdata[76:64]));
        check_field("finished", 32'(due_word.finished), 32'(m_tdata[77]));
        check_field("frame_played", 32'(due_word.played), 32'(m_tuser));
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [1:0] req;
    logic [11:0] addr;
    logic [15:0] len_val;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] pos;
    int pick;

    // reset defaults: unity gains, looping off, zero length
    add_row(1, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h7fffffff, 32'h80000000,
            32'h7fffffff, 32'h80000000, 0, 0, 1);
    add_row(1, REQ_REWIND, 12'hfff, 16'hffff, 16'hffff, 32'h00000001, 32'hffffffff,
            32'h00000001, 32'hffffffff, 0, 0, 1);
    add_row(1, REQ_UNUSED, 12'hfff, 16'hffff, 16'hffff, 32'hffffffff, 32'hffffffff,
            32'hffffffff, 32'hffffffff, 0, 0, 1);
    add_row(1, REQ_LOAD, 12'h000, 16'h7fff, 16'h8000, 32'h00000000, 32'h00000000,
            32'h00000000, 32'h00000000, 0, 0, 1);
    add_row(1, REQ_LOAD, 12'h001, 16'h8000, 16'h7fff, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff, 0, 0, 1);
    add_row(1, REQ_LOAD, 12'h002, 16'hffff, 16'h0001, 32'h12345678, 32'h9abcdef0,
            32'h12345678, 32'h9abcdef0, 0, 0, 1);
    add_row(1, REQ_LOAD, 12'h003, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000,
            32'h00000000, 32'h00000000, 0, 0, 1);
    add_row(1, REQ_LOAD, 12'hfff, 16'h1234, 16'habcd, 32'h00000000, 32'h00000000,
            32'h00000000, 32'h00000000, 0, 0, 1);
    add_cfg(CFG_BUFFER_FRAMES, 16'd4);
    add_cfg(CFG_VOL_LEFT, 16'hffff);
    add_cfg(CFG_VOL_RIGHT, 16'h0000);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 0, 0, 0, 0, 0);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'hffffffff, 32'h00000000, 0, 0, 0, 0, 0);
    // end of buffer with looping off: nothing mixed
    add_row(1, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h55555555, 32'haaaaaaaa,
            32'h55555555, 32'haaaaaaaa, 0, 4, 1);
    add_cfg(CFG_LOOP_ENABLE, 16'd1);
    add_cfg(CFG_VOL_LEFT, 16'h0100);
    add_cfg(CFG_VOL_RIGHT, 16'hffff);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000, 0, 0, 0, 0, 0);
    add_row(1, REQ_REWIND, 12'h000, 16'h0000, 16'h0000, 32'h00000001, 32'h00000002,
            32'h00000001, 32'h00000002, 0, 0, 0);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000000, 32'h80000000, 0, 0, 0, 0, 0);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h7fffffff, 32'h00000000, 0, 0, 0, 0, 0);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000000, 32'h7fffffff, 0, 0, 0, 0, 0);
    // length lowered below the position while looping: wraps
    add_cfg(CFG_BUFFER_FRAMES, 16'd2);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000010, 32'h00000020, 0, 0, 0, 0, 0);
    add_cfg(CFG_LOOP_ENABLE, 16'd0);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000030, 32'h00000040, 0, 0, 0, 0, 0);
    add_cfg(CFG_BUFFER_FRAMES, 16'd1);
    add_row(1, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000,
            32'h00000000, 32'h00000000, 0, 2, 1);
    // length beyond the memory is clipped
    add_cfg(CFG_BUFFER_FRAMES, 16'd5000);
    add_cfg(CFG_LOOP_ENABLE, 16'd1);
    add_row(0, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'hfffffff0, 32'h0000000f, 0, 0, 0, 0, 0);
    // zero length with looping: no wrap, not finished
    add_cfg(CFG_BUFFER_FRAMES, 16'd0);
    add_row(1, REQ_RENDER, 12'h000, 16'h0000, 16'h0000, 32'h00000011, 32'h00000022,
            32'h00000011, 32'h00000022, 0, 3, 0);
    add_row(1, REQ_REWIND, 12'h000, 16'h0000, 16'h0000, 32'h00000000, 32'h00000000,
            32'h00000000, 32'h00000000, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_word(plan[i].req, plan[i].addr, plan[i].smp_l, plan[i].smp_r,
                  plan[i].acc_l, plan[i].acc_r);
        if (plan[i].typed) begin
          void'(voice_step(plan[i].req, plan[i].addr, plan[i].smp_l, plan[i].smp_r,
                           plan[i].acc_l, plan[i].acc_r));
          due_words.push_back(plan[i].want);
        end else begin
          due_words.push_back(voice_step(plan[i].req, plan[i].addr, plan[i].smp_l,
                                         plan[i].smp_r, plan[i].acc_l, plan[i].acc_r));
        end
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 61 : 0;
      rx_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 32 : 0;
      for (int sub = 0; sub < ((ph == 2) ? 4 : 6); sub++) begin
        drain_results();
        write_reg(CFG_VOL_LEFT, pick_gain());
        write_reg(CFG_VOL_RIGHT, pick_gain());
        write_reg(CFG_LOOP_ENABLE, 16'($urandom_range(1)));
        pick = $urandom_range(19);
        if (pick == 0) len_val = 16'd0;
        else if (pick == 1) len_val = 16'd4096;
        else if (pick == 2) len_val = 16'($urandom_range(8191, 4097));
        else if (pick < 6) len_val = 16'($urandom_range(300, 17));
        else len_val = 16'($urandom_range(16, 1));
        write_reg(CFG_BUFFER_FRAMES, len_val);

        repeat (90) begin
          pick = $urandom_range(99);
          if (pick < 30) req = REQ_LOAD;
          else if (pick < 88) req = REQ_RENDER;
          else if (pick < 96) req = REQ_REWIND;
          else req = REQ_UNUSED;
          addr = 12'($urandom);
          len = active_len();
          // loads mostly land inside the playing buffer
          if (req == REQ_LOAD && len != 0 && $urandom_range(3) != 0) begin
            addr = 12'($urandom_range(len - 1));
          end
          // never play a frame that was not loaded: load it instead
          if (req == REQ_RENDER) begin
            pos = play_pos;
            if (pos >= len && loop_on && len != 0) pos = '0;
            if (pos < len && !frame_written[pos[ADDR_W-1:0]]) begin
              req = REQ_LOAD;
              addr = pos[ADDR_W-1:0];
            end
          end
          play_word(req, addr, pick_sample(), pick_sample(), pick_acc(), pick_acc());
          if ($urandom_range(149) == 0) drain_results();
        end
      end
    end

    // short buffer played through to its end, then looped
    drain_results();
    write_reg(CFG_BUFFER_FRAMES, 16'(TAIL_FRAMES));
    write_reg(CFG_LOOP_ENABLE, 16'd0);
    play_word(REQ_REWIND, 12'($urandom), pick_sample(), pick_sample(), pick_acc(), pick_acc());
    for (int f = 0; f < TAIL_FRAMES; f++) begin
      play_word(REQ_LOAD, 12'(f), pick_sample(), pick_sample(), pick_acc(), pick_acc());
      play_word(REQ_RENDER, 12'($urandom), pick_sample(), pick_sample(), pick_acc(), pick_acc());
    end
    play_word(REQ_RENDER, 12'($urandom), pick_sample(), pick_sample(), pick_acc(), pick_acc());
    drain_results();
    write_reg(CFG_LOOP_ENABLE, 16'd1);
    repeat (3) begin
      play_word(REQ_RENDER, 12'($urandom), pick_sample(), pick_sample(), pick_acc(), pick_acc());
    end

    drain_results();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
